>>> design/byte_ring_buffer_drop_oldest_assert.svh
// ----------------------------------------------------------------------------
// Byte ring buffer assertion macros
// Concurrent assertion wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef BYTE_RING_BUFFER_DROP_OLDEST_ASSERT_SVH
`define BYTE_RING_BUFFER_DROP_OLDEST_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication
`define BRB_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("byte ring buffer: same-cycle check failed");
// Next-cycle implication
`define BRB_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("byte ring buffer: next-cycle check failed");
`else
`define BRB_ASSERT_NOW(label, clk, rst, ante, cons)
`define BRB_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

>>> design/brb_pkg.sv
// ----------------------------------------------------------------------------
// brb_pkg
// Shared constants, request codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package brb_pkg;

  localparam int RING_DEPTH = 1024;
  localparam int ADDR_W     = $clog2(RING_DEPTH);
  localparam int PTR_W      = ADDR_W + 1;
  localparam int OCC_W      = 11;
  localparam int MARGIN     = 16;
  localparam int MAX_POP    = 64;
  localparam int CNT_W      = 7;

  // Request codes
  localparam logic [1:0] ACT_PUSH = 2'd0;
  localparam logic [1:0] ACT_POP  = 2'd1;
  localparam logic [1:0] ACT_DROP = 2'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic push;        // store byte, advance write pointer
    logic drop;        // empty the ring
    logic pop_load;    // load byte count for a pop
    logic pop_byte;    // deliver one byte, advance read pointer
    logic emit_single; // load a single non-byte result
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic slot_free;   // output register can take a result this cycle
    logic pop_empty;   // pop request would return no bytes
    logic pop_last;    // one byte left in the current pop
  } dp_stat_t;

endpackage

>>> design/brb_ctrl.sv
// ----------------------------------------------------------------------------
// brb_ctrl
// Controller: accepts requests and sequences multi-byte pops.
// ----------------------------------------------------------------------------
module brb_ctrl import brb_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] action,
  input  dp_stat_t   stat,
  output dp_cmd_t    cmd
);

  typedef enum logic {S_IDLE, S_POP} state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign in_ready = (state == S_IDLE) && stat.slot_free;
  assign accept   = in_valid && in_ready;

  // Decode request and step through pop
  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (action)
            ACT_PUSH: begin
              cmd.push        = 1'b1;
              cmd.emit_single = 1'b1;
            end
            ACT_POP: begin
              if (stat.pop_empty) begin
                cmd.emit_single = 1'b1;
              end else begin
                cmd.pop_load = 1'b1;
                state_next   = S_POP;
              end
            end
            ACT_DROP: begin
              cmd.drop        = 1'b1;
              cmd.emit_single = 1'b1;
            end
            default: begin
              cmd.emit_single = 1'b1;
            end
          endcase
        end
      end
      S_POP: begin
        if (stat.slot_free) begin
          cmd.pop_byte = 1'b1;
          if (stat.pop_last) begin
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> design/brb_datapath.sv
// ----------------------------------------------------------------------------
// brb_datapath
// Pointers, byte memory, pop counter and the result register.
// ----------------------------------------------------------------------------
module brb_datapath import brb_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  dp_cmd_t          cmd,
  output dp_stat_t         stat,
  input  logic [7:0]       data_byte,
  input  logic             chunk_end,
  input  logic [CNT_W-1:0] pop_count,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       byte_out,
  output logic             byte_valid,
  output logic [OCC_W-1:0] occupancy,
  output logic             overflowed,
  output logic             notify,
  output logic             last
);

  localparam logic [PTR_W-1:0] HALF_RING = PTR_W'(RING_DEPTH / 2);
  localparam logic [PTR_W-1:0] OCC_LIMIT = PTR_W'(RING_DEPTH - MARGIN);
  localparam logic [CNT_W-1:0] POP_MAX   = CNT_W'(MAX_POP);

  logic [7:0]       mem [RING_DEPTH];
  logic [7:0]       rd_data;
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W-1:0] wr_ptr_next;
  logic [PTR_W-1:0] rd_ptr_next;
  logic [PTR_W-1:0] occ_now;
  logic [PTR_W-1:0] occ_push;
  logic [PTR_W-1:0] occ_next;
  logic             ovf;
  logic [CNT_W-1:0] pop_lim;
  logic [CNT_W-1:0] pop_n;
  logic [CNT_W-1:0] remaining;

  // Pointer arithmetic wraps modulo twice the ring depth
  assign occ_now  = wr_ptr - rd_ptr;
  assign occ_push = (wr_ptr + PTR_W'(1)) - rd_ptr;
  assign ovf      = cmd.push && (occ_push > OCC_LIMIT);

  always_comb begin
    wr_ptr_next = wr_ptr;
    rd_ptr_next = rd_ptr;
    if (cmd.push) begin
      wr_ptr_next = wr_ptr + PTR_W'(1);
      if (ovf) begin
        rd_ptr_next = wr_ptr_next - HALF_RING;
      end
    end else if (cmd.drop) begin
      rd_ptr_next = wr_ptr;
    end else if (cmd.pop_byte) begin
      rd_ptr_next = rd_ptr + PTR_W'(1);
    end
  end

  assign occ_next = wr_ptr_next - rd_ptr_next;

  // Clamp pop length to the request limit and to what is held
  assign pop_lim = (pop_count > POP_MAX) ? POP_MAX : pop_count;
  assign pop_n   = (occ_now < PTR_W'(pop_lim)) ? occ_now[CNT_W-1:0] : pop_lim;

  assign stat.slot_free = !out_valid || out_ready;
  assign stat.pop_empty = (pop_n == '0);
  assign stat.pop_last  = (remaining == CNT_W'(1));

  // Advance pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
    end
  end

  // Byte memory: write on push, read ahead at the next read pointer
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[wr_ptr[ADDR_W-1:0]] <= data_byte;
    end
    rd_data <= mem[rd_ptr_next[ADDR_W-1:0]];
  end

  // Count down bytes left in the pop
  always_ff @(posedge clk) begin
    if (rst) begin
      remaining <= '0;
    end else if (cmd.pop_load) begin
      remaining <= pop_n;
    end else if (cmd.pop_byte) begin
      remaining <= remaining - CNT_W'(1);
    end
  end

  // Result register: load a result or drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_single || cmd.pop_byte) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pop_byte) begin
      byte_out   <= rd_data;
      byte_valid <= 1'b1;
      occupancy  <= OCC_W'(occ_next);
      overflowed <= 1'b0;
      notify     <= 1'b0;
      last       <= stat.pop_last;
    end else if (cmd.emit_single) begin
      byte_out   <= '0;
      byte_valid <= 1'b0;
      occupancy  <= OCC_W'(occ_next);
      overflowed <= ovf;
      notify     <= cmd.push && chunk_end;
      last       <= 1'b1;
    end
  end

endmodule

>>> design/byte_ring_buffer_drop_oldest.sv
// ----------------------------------------------------------------------------
// byte_ring_buffer_drop_oldest
// Receive byte ring buffer that discards its oldest bytes on overflow.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+---------------------------------------------
//  in      | in_valid / in_ready  | action, data_byte, chunk_end, pop_count
//  out     | out_valid/ out_ready | byte_out, byte_valid, occupancy, overflowed,
//          |                      | notify, last
//
//  Push, drop-all and empty pops: one request per cycle unless a result stalls.
//  A pop returning n bytes occupies the block until its last byte; bytes leave
//  one per cycle unless stalled, set by the byte memory's single read port.
//  Reset clears both pointers; the byte memory needs no clearing.
//  A stalled result holds in the output register and pauses any pop in flight.
// ----------------------------------------------------------------------------
`include "byte_ring_buffer_drop_oldest_assert.svh"

module byte_ring_buffer_drop_oldest import brb_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       action,
  input  logic [7:0]       data_byte,
  input  logic             chunk_end,
  input  logic [CNT_W-1:0] pop_count,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       byte_out,
  output logic             byte_valid,
  output logic [OCC_W-1:0] occupancy,
  output logic             overflowed,
  output logic             notify,
  output logic             last
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Request sequencing
  brb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .action   (action),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Storage and results
  brb_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .data_byte  (data_byte),
    .chunk_end  (chunk_end),
    .pop_count  (pop_count),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .byte_out   (byte_out),
    .byte_valid (byte_valid),
    .occupancy  (occupancy),
    .overflowed (overflowed),
    .notify     (notify),
    .last       (last)
  );

  // Occupancy never climbs past the overflow threshold
  `BRB_ASSERT_NOW(a_occ_bound, clk, rst, out_valid, occupancy <= OCC_W'(RING_DEPTH - MARGIN))
  // An overflow leaves exactly half a ring
  `BRB_ASSERT_NOW(a_ovf_half, clk, rst, out_valid && overflowed, occupancy == OCC_W'(RING_DEPTH / 2))
  // A result without a byte always closes its request
  `BRB_ASSERT_NOW(a_empty_last, clk, rst, out_valid && !byte_valid, last)
  // Mid-pop byte results keep the input side closed
  `BRB_ASSERT_NOW(a_pop_busy, clk, rst, out_valid && byte_valid && !last, !in_ready)
  // A stalled result holds until it is taken
  `BRB_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(byte_out))

endmodule
